// ----- rtl/lrufr_pkg.sv -----
// lrufr_pkg: shared types, codes and the microcode table of the lru frame replacer
// no dependencies; used by lru_frame_replacer
`timescale 1ns / 1ps

package lrufr_pkg;

  localparam int FID_W = 6;
  localparam int CNT_W = 7;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_VICTIM  = 2'd0,
    CMD_PIN     = 2'd1,
    CMD_UNPIN   = 2'd2,
    CMD_RESTORE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [FID_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [FID_W-1:0] victim_frame;
    logic [CNT_W-1:0] evictable_count;
  } rsp_t;

  // datapath operations, one per control word
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_UNLINK,
    ACT_UNLINK_VIC,
    ACT_HEAD_PREP,
    ACT_HEAD_LINK,
    ACT_TAIL_PREP,
    ACT_TAIL_LINK,
    ACT_SET_OK
  } act_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_TAIL_NONE,
    COND_PIN_BAD,
    COND_UNPIN_BAD,
    COND_RESTORE_BAD,
    COND_PRESENT
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_V0   = 4'd0;
  localparam step_t S_V1   = 4'd1;
  localparam step_t S_P0   = 4'd2;
  localparam step_t S_P1   = 4'd3;
  localparam step_t S_U0   = 4'd4;
  localparam step_t S_U1   = 4'd5;
  localparam step_t S_U2   = 4'd6;
  localparam step_t S_R0   = 4'd7;
  localparam step_t S_R1   = 4'd8;
  localparam step_t S_R2   = 4'd9;
  localparam step_t S_R3   = 4'd10;
  localparam step_t S_FAIL = 4'd11;
  localparam step_t S_OKAY = 4'd12;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
    logic  last;
  } ucw_t;

  // control store: act, jump condition, jump target, end of program
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    case (s)
      S_V0:    w = '{act: ACT_NOP,        cond: COND_TAIL_NONE,   target: S_FAIL, last: 1'b0};
      S_V1:    w = '{act: ACT_UNLINK_VIC, cond: COND_NEVER,       target: S_FAIL, last: 1'b1};
      S_P0:    w = '{act: ACT_NOP,        cond: COND_PIN_BAD,     target: S_FAIL, last: 1'b0};
      S_P1:    w = '{act: ACT_UNLINK,     cond: COND_NEVER,       target: S_FAIL, last: 1'b1};
      S_U0:    w = '{act: ACT_NOP,        cond: COND_UNPIN_BAD,   target: S_FAIL, last: 1'b0};
      S_U1:    w = '{act: ACT_HEAD_PREP,  cond: COND_NEVER,       target: S_FAIL, last: 1'b0};
      S_U2:    w = '{act: ACT_HEAD_LINK,  cond: COND_NEVER,       target: S_FAIL, last: 1'b1};
      S_R0:    w = '{act: ACT_NOP,        cond: COND_RESTORE_BAD, target: S_FAIL, last: 1'b0};
      S_R1:    w = '{act: ACT_NOP,        cond: COND_PRESENT,     target: S_OKAY, last: 1'b0};
      S_R2:    w = '{act: ACT_TAIL_PREP,  cond: COND_NEVER,       target: S_FAIL, last: 1'b0};
      S_R3:    w = '{act: ACT_TAIL_LINK,  cond: COND_NEVER,       target: S_FAIL, last: 1'b1};
      S_OKAY:  w = '{act: ACT_SET_OK,     cond: COND_NEVER,       target: S_FAIL, last: 1'b1};
      default: w = '{act: ACT_NOP,        cond: COND_NEVER,       target: S_FAIL, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lrufr_ram.sv -----
// lrufr_ram: generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module lrufr_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lru_frame_replacer.sv -----
// lru_frame_replacer: lru list of evictable frames run by a small microcoded sequencer
// depends on lrufr_pkg and lrufr_ram
`timescale 1ns / 1ps

//  channel    signals                          direction  transfer
//  --------   ------------------------------   ---------  ------------------------------
//  command    start, busy, req                 in         word taken on start & !busy
//  result     done, rsp                        out        word shown for one cycle on done
//  config     cfg_valid, cfg_ready, cfg_data   in         frames_in_use on valid & ready
//
//  one word at a time, taken only while busy is low; victim and pin run the shortest
//  programs, restore of an absent frame the longest; the step count follows from the
//  registered read of the link rams (links are known only after the first step) and
//  their single write ports (two writes to one ram take two steps)
//  synchronous reset empties the list at once: in_list is flip-flops, the link rams need
//  no clearing since a link is only read for a frame that is in the list
//  done is high the cycle after the last step; busy drops in that same cycle, so the next
//  word may be taken while the result is shown; results cannot be stalled

module lru_frame_replacer #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  lrufr_pkg::req_t              req,
  output logic                         done,
  output lrufr_pkg::rsp_t              rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrufr_pkg::CFG_W-1:0]  cfg_data
);

  // only ids below 2**FID_W can ever be named, so storage stops there
  localparam int ID_SPAN = 1 << lrufr_pkg::FID_W;
  localparam int DEPTH   = (NUM_FRAMES < ID_SPAN) ? NUM_FRAMES : ID_SPAN;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LINK_W  = $clog2(DEPTH + 1);
  localparam int CFG_MAX = (1 << lrufr_pkg::CFG_W) - 1;
  localparam int CAP     = (NUM_FRAMES > CFG_MAX) ? CFG_MAX : NUM_FRAMES;

  localparam logic [LINK_W-1:0]           LINK_NONE = LINK_W'(DEPTH);
  localparam logic [lrufr_pkg::CNT_W-1:0] CAP_V     = lrufr_pkg::CNT_W'(CAP);

  // control and list state
  logic [lrufr_pkg::CFG_W-1:0] frames_in_use;
  lrufr_pkg::step_t            pc, pc_next, entry;
  logic [LINK_W-1:0]           head, head_next;
  logic [LINK_W-1:0]           tail, tail_next;
  logic [lrufr_pkg::CNT_W-1:0] count, count_next;
  logic [DEPTH-1:0]            in_list, in_list_next;

  // payload of the word in flight
  logic [lrufr_pkg::FID_W-1:0] fid;
  logic [IDX_W-1:0]            cur;

  // link rams
  logic              prev_we, next_we;
  logic [IDX_W-1:0]  prev_waddr, next_waddr;
  logic [LINK_W-1:0] prev_wdata, next_wdata;
  logic [LINK_W-1:0] prev_q, next_q;

  lrufr_pkg::ucw_t             ucw;
  logic [lrufr_pkg::CNT_W-1:0] limit;
  logic                        fid_valid, present, jump, ok_set, vic_set, accept;
  logic [LINK_W-1:0]           cur_link;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign ucw       = lrufr_pkg::ucode(pc);
  assign cur_link  = LINK_W'(cur);

  // a limit above the frame count saturates
  assign limit     = (frames_in_use < CAP_V) ? frames_in_use : CAP_V;
  assign fid_valid = lrufr_pkg::CNT_W'(fid) < limit;
  assign present   = in_list[cur];

  lrufr_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (cur),
    .rdata (prev_q)
  );

  lrufr_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (cur),
    .rdata (next_q)
  );

  // program entry per command
  always_comb begin
    unique case (req.command)
      lrufr_pkg::CMD_VICTIM:  entry = lrufr_pkg::S_V0;
      lrufr_pkg::CMD_PIN:     entry = lrufr_pkg::S_P0;
      lrufr_pkg::CMD_UNPIN:   entry = lrufr_pkg::S_U0;
      lrufr_pkg::CMD_RESTORE: entry = lrufr_pkg::S_R0;
      default:                entry = lrufr_pkg::S_FAIL;
    endcase
  end

  // jump condition and step counter
  always_comb begin
    unique case (ucw.cond)
      lrufr_pkg::COND_NEVER:       jump = 1'b0;
      lrufr_pkg::COND_TAIL_NONE:   jump = (tail == LINK_NONE);
      lrufr_pkg::COND_PIN_BAD:     jump = !(fid_valid && present);
      lrufr_pkg::COND_UNPIN_BAD:   jump = !(fid_valid && !present && (count < limit));
      lrufr_pkg::COND_RESTORE_BAD: jump = !fid_valid;
      lrufr_pkg::COND_PRESENT:     jump = present;
      default:                     jump = 1'b0;
    endcase
    pc_next = jump ? ucw.target : lrufr_pkg::step_t'(pc + 4'd1);
  end

  // datapath driven by the control word
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    in_list_next = in_list;
    prev_we      = 1'b0;
    prev_waddr   = cur;
    prev_wdata   = LINK_NONE;
    next_we      = 1'b0;
    next_waddr   = cur;
    next_wdata   = LINK_NONE;
    ok_set       = 1'b0;
    vic_set      = 1'b0;
    if (busy) begin
      case (ucw.act) inside
        lrufr_pkg::ACT_UNLINK, lrufr_pkg::ACT_UNLINK_VIC: begin
          // bridge the neighbors of cur
          if (prev_q != LINK_NONE) begin
            next_we    = 1'b1;
            next_waddr = prev_q[IDX_W-1:0];
            next_wdata = next_q;
          end else begin
            head_next = next_q;
          end
          if (next_q != LINK_NONE) begin
            prev_we    = 1'b1;
            prev_waddr = next_q[IDX_W-1:0];
            prev_wdata = prev_q;
          end else begin
            tail_next = prev_q;
          end
          in_list_next[cur] = 1'b0;
          if (count != '0) begin
            count_next = count - 1'b1;
          end
          ok_set  = 1'b1;
          vic_set = (ucw.act == lrufr_pkg::ACT_UNLINK_VIC);
        end
        lrufr_pkg::ACT_HEAD_PREP: begin
          prev_we    = 1'b1;
          prev_wdata = LINK_NONE;
          next_we    = 1'b1;
          next_wdata = head;
        end
        lrufr_pkg::ACT_HEAD_LINK: begin
          if (head != LINK_NONE) begin
            prev_we    = 1'b1;
            prev_waddr = head[IDX_W-1:0];
            prev_wdata = cur_link;
          end else begin
            tail_next = cur_link;
          end
          head_next         = cur_link;
          in_list_next[cur] = 1'b1;
          count_next        = count + 1'b1;
          ok_set            = 1'b1;
        end
        lrufr_pkg::ACT_TAIL_PREP: begin
          next_we    = 1'b1;
          next_wdata = LINK_NONE;
          prev_we    = 1'b1;
          prev_wdata = tail;
        end
        lrufr_pkg::ACT_TAIL_LINK: begin
          if (tail != LINK_NONE) begin
            next_we    = 1'b1;
            next_waddr = tail[IDX_W-1:0];
            next_wdata = cur_link;
          end else begin
            head_next = cur_link;
          end
          tail_next         = cur_link;
          in_list_next[cur] = 1'b1;
          count_next        = count + 1'b1;
          ok_set            = 1'b1;
        end
        lrufr_pkg::ACT_SET_OK: begin
          ok_set = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // control and list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      done          <= 1'b0;
      pc            <= lrufr_pkg::S_V0;
      head          <= LINK_NONE;
      tail          <= LINK_NONE;
      count         <= '0;
      in_list       <= '0;
      frames_in_use <= lrufr_pkg::CFG_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        frames_in_use <= cfg_data;
      end
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      in_list <= in_list_next;
      if (accept) begin
        busy <= 1'b1;
        pc   <= entry;
      end else if (busy) begin
        pc <= pc_next;
        if (ucw.last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      fid <= req.frame;
      // victim works on the tail frame, the others on the given id
      cur <= (req.command == lrufr_pkg::CMD_VICTIM) ? tail[IDX_W-1:0]
                                                     : req.frame[IDX_W-1:0];
    end
    if (busy && ucw.last) begin
      rsp.ok              <= ok_set;
      rsp.victim_frame    <= vic_set ? lrufr_pkg::FID_W'(cur) : '0;
      rsp.evictable_count <= count_next;
    end
  end

  // an empty list has neither head nor count
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (head == LINK_NONE) == (count == '0))
    else $error("head link and list count disagree");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (head == LINK_NONE) == (tail == LINK_NONE))
    else $error("head and tail links disagree on empty list");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("accepted word did not start the sequencer");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("sequencer finished without a result strobe");

  a_victim_ok: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.victim_frame != '0) |-> rsp.ok)
    else $error("victim frame reported on a failed command");

endmodule

// ----- dv/lru_frame_replacer_tb.sv -----
// lru_frame_replacer_tb: self-checking testbench for the lru frame replacer
// drives command and config words, predicts each result word and checks it
// depends on lrufr_pkg and lru_frame_replacer
`timescale 1ns / 1ps

module lru_frame_replacer_tb;

  localparam int          FRAMES      = 64;
  localparam logic [6:0]  NO_LINK     = 7'd64;  // end-of-list marker
  localparam int          STALL_LIMIT = 1000;   // cycles with no word moving on any channel
  localparam int          RANDOM_ITEMS = 1420;
  localparam int          PHASES      = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  lrufr_pkg::req_t req = '0;
  logic       done;
  lrufr_pkg::rsp_t rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [lrufr_pkg::CFG_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  lru_frame_replacer #(
    .NUM_FRAMES(FRAMES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // shadow of the replacer: newest frame at the mru end, next victim at the lru end
  // ---------------------------------------------------------------------------
  logic [6:0] mru_end;
  logic [6:0] lru_end;
  logic [6:0] newer_of [FRAMES];   // link toward the mru end
  logic [6:0] older_of [FRAMES];   // link toward the lru end
  logic       listed   [FRAMES];
  logic [6:0] listed_cnt;
  logic [6:0] frame_limit_reg;     // frames_in_use as written

  lrufr_pkg::rsp_t expected_rsp[$];  // result words still owed by the block
  int         err_count = 0;
  bit         no_gaps = 1'b0;      // burst stretches with the sender never idle

  // frames_in_use saturates at the frame count
  function automatic logic [6:0] active_limit();
    return (frame_limit_reg < 7'(FRAMES)) ? frame_limit_reg : 7'(FRAMES);
  endfunction

  function automatic void drop_frame(logic [5:0] f);
    logic [6:0] nw;
    logic [6:0] od;
    nw = newer_of[f];
    od = older_of[f];
    if (nw != NO_LINK) older_of[nw[5:0]] = od;
    else mru_end = od;
    if (od != NO_LINK) newer_of[od[5:0]] = nw;
    else lru_end = nw;
    newer_of[f] = NO_LINK;
    older_of[f] = NO_LINK;
    listed[f] = 1'b0;
    if (listed_cnt > 0) listed_cnt = listed_cnt - 7'd1;
  endfunction

  // applies one command word to the shadow list and returns the result word
  function automatic lrufr_pkg::rsp_t apply_command(lrufr_pkg::req_t r);
    logic [6:0] lim;
    logic [5:0] f;
    logic       id_ok;
    lrufr_pkg::rsp_t res;
    lim = active_limit();
    f = r.frame;
    id_ok = ({1'b0, f} < lim);
    res = '0;
    case (r.command)
      lrufr_pkg::CMD_VICTIM: begin
        if (lru_end != NO_LINK) begin
          res.victim_frame = lru_end[5:0];
          drop_frame(lru_end[5:0]);
          res.ok = 1'b1;
        end
      end
      lrufr_pkg::CMD_PIN: begin
        if (id_ok && listed[f]) begin
          drop_frame(f);
          res.ok = 1'b1;
        end
      end
      lrufr_pkg::CMD_UNPIN: begin
        // only an absent frame, and only while the list is below the limit
        if (id_ok && !listed[f] && listed_cnt < lim) begin
          newer_of[f] = NO_LINK;
          older_of[f] = mru_end;
          if (mru_end != NO_LINK) newer_of[mru_end[5:0]] = {1'b0, f};
          else lru_end = {1'b0, f};
          mru_end = {1'b0, f};
          listed[f] = 1'b1;
          listed_cnt = listed_cnt + 7'd1;
          res.ok = 1'b1;
        end
      end
      default: begin
        // restore: absent frame goes to the lru end, present frame stays put
        if (id_ok) begin
          if (!listed[f]) begin
            older_of[f] = NO_LINK;
            newer_of[f] = lru_end;
            if (lru_end != NO_LINK) older_of[lru_end[5:0]] = {1'b0, f};
            else mru_end = {1'b0, f};
            lru_end = {1'b0, f};
            listed[f] = 1'b1;
            listed_cnt = listed_cnt + 7'd1;
          end
          res.ok = 1'b1;
        end
      end
    endcase
    res.evictable_count = listed_cnt;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking: every done strobe is compared with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    lrufr_pkg::rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $error("result word with nothing expected: ok %0d victim_frame %0d count %0d",
               rsp.ok, rsp.victim_frame, rsp.evictable_count);
        err_count = err_count + 1;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
          err_count = err_count + 1;
        end
        if (rsp.victim_frame !== want.victim_frame) begin
          $error("victim_frame: expected %0d, got %0d", want.victim_frame, rsp.victim_frame);
          err_count = err_count + 1;
        end
        if (rsp.evictable_count !== want.evictable_count) begin
          $error("evictable_count: expected %0d, got %0d",
                 want.evictable_count, rsp.evictable_count);
          err_count = err_count + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no word moves on any channel for too long
  // ---------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** lru_frame_replacer: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one command word, waits until it is taken, records the expected result
  // and then idles for a random gap; start stays high when the gap is zero
  task automatic issue_command(lrufr_pkg::cmd_t c, logic [5:0] f);
    int roll;
    int gap;
    lrufr_pkg::req_t item;
    item.command = c;
    item.frame = f;
    start <= 1'b1;
    req <= item;
    do @(posedge clk); while (busy);
    expected_rsp.push_back(apply_command(item));
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 50) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // holds the sender off until every expected result word has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0 || busy);
  endtask

  // writes frames_in_use; only called with the block idle
  task automatic write_frame_limit(logic [lrufr_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_limit_reg = value;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset limit: empty victim, pin of an absent frame, unpin and restore of
  // present frames, restore to the lru end and victim order
  task automatic test_basic_commands();
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd0);
    issue_command(lrufr_pkg::CMD_PIN, 6'd7);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd0);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd63);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd0);
    issue_command(lrufr_pkg::CMD_RESTORE, 6'd5);
    issue_command(lrufr_pkg::CMD_RESTORE, 6'd63);
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd63);
    issue_command(lrufr_pkg::CMD_PIN, 6'd63);
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd0);
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd21);
  endtask

  // limit lowered to the listed count: unpin refused at the limit, high ids
  // refused, restore still allowed, victim still returns out-of-range frames
  task automatic test_lowered_limit();
    drain_results();
    write_frame_limit(7'd64);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd12);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd10);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd0);
    drain_results();
    write_frame_limit(7'd3);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd1);
    issue_command(lrufr_pkg::CMD_PIN, 6'd12);
    issue_command(lrufr_pkg::CMD_RESTORE, 6'd2);
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd0);
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd0);
  endtask

  // zero limit rejects every id for pin, unpin and restore; victim still works; a limit above the frame count saturates
  task automatic test_zero_and_saturated_limit();
    drain_results();
    write_frame_limit(7'd0);
    issue_command(lrufr_pkg::CMD_RESTORE, 6'd0);
    issue_command(lrufr_pkg::CMD_PIN, 6'd0);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd0);
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd0);
    drain_results();
    write_frame_limit(7'd127);
    issue_command(lrufr_pkg::CMD_UNPIN, 6'd63);
    issue_command(lrufr_pkg::CMD_RESTORE, 6'd62);
    issue_command(lrufr_pkg::CMD_VICTIM, 6'd0);
    issue_command(lrufr_pkg::CMD_PIN, 6'd63);
  endtask

  // random traffic in phases of different limits; even phases mostly fill the
  // list, odd phases mostly drain it, with a little noise throughout
  task automatic test_random_traffic();
    logic [6:0] phase_limit [PHASES];
    logic [6:0] lim;
    logic [5:0] fid;
    lrufr_pkg::cmd_t c;
    int         roll;
    int         sel;
    int         scan_from;
    int         idx;
    bit         found;
    phase_limit = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd65, 7'd20, 7'd0, 7'd64, 7'd8, 7'd64};
    phase_limit[8] = 7'($urandom_range(3, 63));
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_frame_limit(phase_limit[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ((phase_limit[p] == 0) ? 40 : RANDOM_ITEMS / (PHASES - 1)); n++) begin
        lim = active_limit();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: any command, any id
          c = lrufr_pkg::cmd_t'($urandom_range(0, 3));
          fid = 6'($urandom_range(0, 63));
        end else begin
          sel = $urandom_range(0, 99);
          if (p % 2 == 0) begin
            if (sel < 15) c = lrufr_pkg::CMD_VICTIM;
            else if (sel < 30) c = lrufr_pkg::CMD_PIN;
            else if (sel < 80) c = lrufr_pkg::CMD_UNPIN;
            else c = lrufr_pkg::CMD_RESTORE;
          end else begin
            if (sel < 40) c = lrufr_pkg::CMD_VICTIM;
            else if (sel < 65) c = lrufr_pkg::CMD_PIN;
            else if (sel < 85) c = lrufr_pkg::CMD_UNPIN;
            else c = lrufr_pkg::CMD_RESTORE;
          end
          if (lim == 0) fid = 6'($urandom_range(0, 63));
          else fid = 6'($urandom_range(0, lim - 1));
          // pin mostly hits a listed frame, found by a scan from a random id;
          // restore sometimes does, to cover restore of a present frame
          if ((c == lrufr_pkg::CMD_PIN && $urandom_range(0, 3) != 0) ||
              (c == lrufr_pkg::CMD_RESTORE && $urandom_range(0, 3) == 0)) begin
            scan_from = $urandom_range(0, FRAMES - 1);
            found = 1'b0;
            for (int k = 0; k < FRAMES; k++) begin
              idx = (scan_from + k) % FRAMES;
              if (!found && listed[idx] && idx < lim) begin
                fid = idx[5:0];
                found = 1'b1;
              end
            end
          end
        end
        issue_command(c, fid);
        // now and then the sender waits for every result before going on
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    mru_end = NO_LINK;
    lru_end = NO_LINK;
    for (int i = 0; i < FRAMES; i++) begin
      newer_of[i] = NO_LINK;
      older_of[i] = NO_LINK;
      listed[i] = 1'b0;
    end
    listed_cnt = '0;
    frame_limit_reg = lrufr_pkg::CFG_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_commands();
    test_lowered_limit();
    test_zero_and_saturated_limit();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0 && expected_rsp.size() == 0) begin
      $display("** lru_frame_replacer: PASSED **");
    end else begin
      $display("** lru_frame_replacer: FAILED **");
    end
    $finish;
  end

endmodule
